// ----- sv/mcpa_pkg.sv -----
// Shared constants, codes and types of the midpoint circle pixel addresser.
package mcpa_pkg;

	localparam int COORD_BITS = 12;
	localparam int RADIUS_BITS = COORD_BITS - 1;
	localparam int POINT_BITS = 14;
	localparam int REG_BITS = 13;
	localparam int ERR_BITS = 16;
	localparam int ADDR_BITS = 26;
	localparam int COLOR_BITS = 32;
	localparam int BYTES_PER_PIXEL = 4;

	localparam int POINTS_PER_STEP = 8;
	localparam int SEQ_BITS = $clog2(POINTS_PER_STEP);

	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	localparam logic [REG_BITS-1:0] LINE_WIDTH_RESET = REG_BITS'(640);
	localparam logic [REG_BITS-1:0] SCREEN_HEIGHT_RESET = REG_BITS'(480);

	typedef enum logic {
		CFG_LINE_WIDTH = 1'b0,
		CFG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_START = 1'b0,
		MODE_CONTINUE = 1'b1
	} mode_t;

	// One midpoint step handed from the front end to the point generator.
	typedef struct packed {
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [COORD_BITS-1:0] ox;
		logic [COORD_BITS-1:0] oy;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} step_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- sv/mcpa_front.sv -----
// Front end: accepts start and continue transactions and runs the midpoint recurrence.
module mcpa_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic [mcpa_pkg::COORD_BITS-1:0]       origin_x,
	input  logic [mcpa_pkg::COORD_BITS-1:0]       origin_y,
	input  logic [mcpa_pkg::RADIUS_BITS-1:0]      radius,
	input  logic [mcpa_pkg::COLOR_BITS-1:0]       color,
	input  mcpa_pkg::q_status_t                   q_status,
	output logic                                  push,
	output mcpa_pkg::step_cmd_t                   push_cmd
);

	logic [mcpa_pkg::COORD_BITS-1:0] cx_q, cy_q, x_q, y_q;
	logic [mcpa_pkg::COLOR_BITS-1:0] color_q;
	logic signed [mcpa_pkg::ERR_BITS-1:0] err_q;
	logic active_q;

	logic is_start, accept;
	logic [mcpa_pkg::COORD_BITS-1:0] bx, by;
	logic signed [mcpa_pkg::ERR_BITS-1:0] be, e1, x1e, y1e;
	logic signed [mcpa_pkg::COORD_BITS:0] x1, y1;
	logic last;

	assign in_stall = q_status.full;
	assign is_start = (mode == mcpa_pkg::MODE_START);
	assign accept = in_valid && !q_status.full;
	assign push = accept && (is_start || active_q);

	always_comb begin
		bx = is_start ? mcpa_pkg::COORD_BITS'(radius) : x_q;
		by = is_start ? '0 : y_q;
		be = is_start ? (mcpa_pkg::ERR_BITS'(1) - mcpa_pkg::ERR_BITS'(radius)) : err_q;
		y1 = $signed({1'b0, by}) + $signed((mcpa_pkg::COORD_BITS+1)'(1));
		y1e = mcpa_pkg::ERR_BITS'(y1);
		if (be[mcpa_pkg::ERR_BITS-1]) begin
			x1 = $signed({1'b0, bx});
			x1e = mcpa_pkg::ERR_BITS'(x1);
			e1 = be + (y1e <<< 1) + mcpa_pkg::ERR_BITS'(1);
		end else begin
			x1 = $signed({1'b0, bx}) - $signed((mcpa_pkg::COORD_BITS+1)'(1));
			x1e = mcpa_pkg::ERR_BITS'(x1);
			e1 = be + ((y1e - x1e + mcpa_pkg::ERR_BITS'(1)) <<< 1);
		end
		last = (x1 < y1);
	end

	always_comb begin
		push_cmd.cx = is_start ? origin_x : cx_q;
		push_cmd.cy = is_start ? origin_y : cy_q;
		push_cmd.ox = bx;
		push_cmd.oy = by;
		push_cmd.color = is_start ? color : color_q;
		push_cmd.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			x_q <= '0;
			y_q <= '0;
			color_q <= '0;
			err_q <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			if (is_start) begin
				cx_q <= origin_x;
				cy_q <= origin_y;
				color_q <= color;
			end
			active_q <= !last;
			if (!last) begin
				x_q <= x1[mcpa_pkg::COORD_BITS-1:0];
				y_q <= y1[mcpa_pkg::COORD_BITS-1:0];
				err_q <= e1;
			end
		end
	end

endmodule

// ----- sv/mcpa_queue.sv -----
// Small step queue between the front end and the point generator.
module mcpa_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mcpa_pkg::step_cmd_t  push_cmd,
	input  logic                 pop,
	output mcpa_pkg::step_cmd_t  head_cmd,
	output mcpa_pkg::q_status_t  q_status
);

	mcpa_pkg::step_cmd_t mem_q [mcpa_pkg::QDEPTH];
	logic [mcpa_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [mcpa_pkg::QCNT_BITS-1:0] count_q;

	assign head_cmd = mem_q[rd_ptr_q];
	assign q_status.full = (count_q == mcpa_pkg::QCNT_BITS'(mcpa_pkg::QDEPTH));
	assign q_status.empty = (count_q == '0);

	function automatic logic [mcpa_pkg::QPTR_BITS-1:0] next_ptr(
		input logic [mcpa_pkg::QPTR_BITS-1:0] p);
		next_ptr = (p == mcpa_pkg::QPTR_BITS'(mcpa_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/mcpa_back.sv -----
// Point generator: expands each step into eight mirrored points and addresses them.
module mcpa_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mcpa_pkg::q_status_t                   q_status,
	input  mcpa_pkg::step_cmd_t                   head_cmd,
	output logic                                  pop,
	input  logic [mcpa_pkg::REG_BITS-1:0]         line_width,
	input  logic [mcpa_pkg::REG_BITS-1:0]         screen_height,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [mcpa_pkg::POINT_BITS-1:0] point_x,
	output logic signed [mcpa_pkg::POINT_BITS-1:0] point_y,
	output logic [mcpa_pkg::ADDR_BITS-1:0]        byte_address,
	output logic [mcpa_pkg::COLOR_BITS-1:0]       pixel_color,
	output logic                                  off_screen,
	output logic                                  last_point
);

	logic [mcpa_pkg::SEQ_BITS-1:0] seq_q;
	logic en, take, last_of_step;
	logic swap, negx, negy;
	logic [mcpa_pkg::COORD_BITS-1:0] ax, ay;
	logic signed [mcpa_pkg::POINT_BITS-1:0] px, py;
	logic off;

	logic v_s1, v_s2;
	logic signed [mcpa_pkg::POINT_BITS-1:0] px_s1, py_s1, px_s2, py_s2;
	logic [mcpa_pkg::COLOR_BITS-1:0] color_s1, color_s2;
	logic off_s1, off_s2, last_s1, last_s2;
	logic [mcpa_pkg::ADDR_BITS-1:0] prod_s2;

	logic out_valid_q, off_q, last_q;
	logic signed [mcpa_pkg::POINT_BITS-1:0] px_q, py_q;
	logic [mcpa_pkg::ADDR_BITS-1:0] addr_q;
	logic [mcpa_pkg::COLOR_BITS-1:0] color_q;

	assign en = !(out_valid_q && out_stall);
	assign take = en && !q_status.empty;
	assign last_of_step = (seq_q == mcpa_pkg::SEQ_BITS'(mcpa_pkg::POINTS_PER_STEP - 1));
	assign pop = take && last_of_step;

	// Octant order: swap on odd points, mirror x on points two to five, mirror y on the upper half.
	always_comb begin
		swap = seq_q[0];
		negx = seq_q[2] ^ seq_q[1];
		negy = seq_q[2];
		ax = swap ? head_cmd.oy : head_cmd.ox;
		ay = swap ? head_cmd.ox : head_cmd.oy;
		px = negx ? (mcpa_pkg::POINT_BITS'(head_cmd.cx) - mcpa_pkg::POINT_BITS'(ax))
		          : (mcpa_pkg::POINT_BITS'(head_cmd.cx) + mcpa_pkg::POINT_BITS'(ax));
		py = negy ? (mcpa_pkg::POINT_BITS'(head_cmd.cy) - mcpa_pkg::POINT_BITS'(ay))
		          : (mcpa_pkg::POINT_BITS'(head_cmd.cy) + mcpa_pkg::POINT_BITS'(ay));
		off = px[mcpa_pkg::POINT_BITS-1] || py[mcpa_pkg::POINT_BITS-1]
			|| ($unsigned(px) >= mcpa_pkg::POINT_BITS'(line_width))
			|| ($unsigned(py) >= mcpa_pkg::POINT_BITS'(screen_height));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (take) begin
				seq_q <= seq_q + 1'b1;
			end
			v_s1 <= take;
			v_s2 <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px;
			py_s1 <= py;
			color_s1 <= head_cmd.color;
			off_s1 <= off;
			last_s1 <= head_cmd.last && last_of_step;

			prod_s2 <= mcpa_pkg::ADDR_BITS'(py_s1[mcpa_pkg::REG_BITS-1:0])
				* mcpa_pkg::ADDR_BITS'(line_width);
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			color_s2 <= color_s1;
			off_s2 <= off_s1;
			last_s2 <= last_s1;

			px_q <= px_s2;
			py_q <= py_s2;
			color_q <= color_s2;
			off_q <= off_s2;
			last_q <= last_s2;
			addr_q <= off_s2 ? '0
				: mcpa_pkg::ADDR_BITS'((prod_s2
					+ mcpa_pkg::ADDR_BITS'(px_s2[mcpa_pkg::REG_BITS-1:0]))
					* mcpa_pkg::ADDR_BITS'(mcpa_pkg::BYTES_PER_PIXEL));
		end
	end

	assign out_valid = out_valid_q;
	assign point_x = px_q;
	assign point_y = py_q;
	assign byte_address = addr_q;
	assign pixel_color = color_q;
	assign off_screen = off_q;
	assign last_point = last_q;

endmodule

// ----- sv/midpoint_circle_pixel_addresser.sv -----
// Top level of the midpoint circle pixel addresser with its configuration registers.
//
// A start transaction (mode 0) latches a circle's center, radius and color and yields the
// eight mirrored points of the first midpoint step; each continue transaction (mode 1)
// advances one step and yields eight more, and the final point of the circle carries
// last_point. A continue with no circle in progress is absorbed and yields nothing. Every
// point leaves with its coordinates, the color and the byte offset (x + y*line_width)*4,
// which is zero when off_screen flags the point as outside line_width or screen_height.
// The generator emits one point per cycle, unless out_stall holds the output, through a single
// multiply stage. A step's points pass from the queue through the s1 and s2 registers and the
// output registers. A four-deep step queue sits between the recurrence and the generator,
// so input transactions are taken one per cycle until the queue fills, and an ignored
// continue is taken like any other. Configuration writes are always ready and must only
// be issued while the block is idle.
module midpoint_circle_pixel_addresser (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   mode,
	input  logic [mcpa_pkg::COORD_BITS-1:0]        origin_x,
	input  logic [mcpa_pkg::COORD_BITS-1:0]        origin_y,
	input  logic [mcpa_pkg::RADIUS_BITS-1:0]       radius,
	input  logic [mcpa_pkg::COLOR_BITS-1:0]        color,

	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [mcpa_pkg::POINT_BITS-1:0] point_x,
	output logic signed [mcpa_pkg::POINT_BITS-1:0] point_y,
	output logic [mcpa_pkg::ADDR_BITS-1:0]         byte_address,
	output logic [mcpa_pkg::COLOR_BITS-1:0]        pixel_color,
	output logic                                   off_screen,
	output logic                                   last_point,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic                                   cfg_index,
	input  logic [mcpa_pkg::REG_BITS-1:0]          cfg_data
);

	logic [mcpa_pkg::REG_BITS-1:0] line_width_q;
	logic [mcpa_pkg::REG_BITS-1:0] screen_height_q;

	logic push, pop;
	mcpa_pkg::step_cmd_t push_cmd, head_cmd;
	mcpa_pkg::q_status_t q_status;

	// The register file never holds off a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= mcpa_pkg::LINE_WIDTH_RESET;
			screen_height_q <= mcpa_pkg::SCREEN_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (mcpa_pkg::cfg_reg_t'(cfg_index))
				mcpa_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_data;
				mcpa_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: line_width_q <= line_width_q;
			endcase
		end
	end

	// The front end owns the circle state and turns each accepted transaction
	// that produces points into one queued step.
	mcpa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.radius   (radius),
		.color    (color),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mcpa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_status (q_status)
	);

	// The back end walks the eight octants of the head step and pops it after
	// the eighth point has entered its pipeline.
	mcpa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.line_width    (line_width_q),
		.screen_height (screen_height_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.point_x       (point_x),
		.point_y       (point_y),
		.byte_address  (byte_address),
		.pixel_color   (pixel_color),
		.off_screen    (off_screen),
		.last_point    (last_point)
	);

endmodule

// ----- test/midpoint_circle_pixel_addresser_tb.sv -----
// Self-checking testbench for the midpoint circle pixel addresser.
`timescale 1ns / 1ps

module midpoint_circle_pixel_addresser_tb;
	import mcpa_pkg::*;

	// One emitted framebuffer point, as it leaves the block.
	typedef struct packed {
		logic signed [POINT_BITS-1:0] px;
		logic signed [POINT_BITS-1:0] py;
		logic [ADDR_BITS-1:0]         addr;
		logic [COLOR_BITS-1:0]        color;
		logic                         off;
		logic                         last;
	} point_rec_t;

	// Tracks the rasterizer state, predicts the points of every accepted transaction and
	// checks the points that come out against them in order.
	class circle_scoreboard;
		logic [REG_BITS-1:0]   line_width;
		logic [REG_BITS-1:0]   screen_height;
		logic [COORD_BITS-1:0] center_col;
		logic [COORD_BITS-1:0] center_row;
		logic [COLOR_BITS-1:0] pen_color;
		logic [REG_BITS-1:0]   step_x;
		logic [REG_BITS-1:0]   step_y;
		int                    decision_error;
		bit                    circle_active;
		point_rec_t            expected_points[$];
		int                    mismatches;

		function new();
			line_width = LINE_WIDTH_RESET;
			screen_height = SCREEN_HEIGHT_RESET;
			center_col = '0;
			center_row = '0;
			pen_color = '0;
			step_x = '0;
			step_y = '0;
			decision_error = 0;
			circle_active = 0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [REG_BITS-1:0] value);
			if (idx == CFG_LINE_WIDTH) begin
				line_width = value;
			end else begin
				screen_height = value;
			end
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		function bit active();
			return circle_active;
		endfunction

		function void push_point(int px, int py, bit last);
			point_rec_t rec;
			int lw;
			int rows;
			longint lin;
			lw = int'(line_width);
			rows = int'(screen_height);
			rec.off = (px < 0) || (py < 0) || (px >= lw) || (py >= rows);
			lin = (longint'(px) + longint'(py) * longint'(lw)) * BYTES_PER_PIXEL;
			rec.addr = rec.off ? '0 : lin[ADDR_BITS-1:0];
			rec.px = px[POINT_BITS-1:0];
			rec.py = py[POINT_BITS-1:0];
			rec.color = pen_color;
			rec.last = last;
			expected_points.push_back(rec);
		endfunction

		// Eight mirrored points of the current step, then the midpoint recurrence.
		function void emit_step();
			int cx;
			int cy;
			int ox;
			int oy;
			int x;
			int y;
			int e;
			bit last;
			cx = int'(center_col);
			cy = int'(center_row);
			ox = int'(step_x);
			oy = int'(step_y);
			x = ox;
			y = oy + 1;
			e = decision_error;
			if (e < 0) begin
				e += 2 * y + 1;
			end else begin
				x -= 1;
				e += 2 * (y - x + 1);
			end
			last = !(x >= y);
			push_point(cx + ox, cy + oy, 0);
			push_point(cx + oy, cy + ox, 0);
			push_point(cx - ox, cy + oy, 0);
			push_point(cx - oy, cy + ox, 0);
			push_point(cx - ox, cy - oy, 0);
			push_point(cx - oy, cy - ox, 0);
			push_point(cx + ox, cy - oy, 0);
			push_point(cx + oy, cy - ox, last);
			if (last) begin
				circle_active = 0;
			end else begin
				step_x = x[REG_BITS-1:0];
				step_y = y[REG_BITS-1:0];
				decision_error = e;
			end
		endfunction

		function void note_input(mode_t m, logic [COORD_BITS-1:0] cx,
				logic [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] r,
				logic [COLOR_BITS-1:0] col);
			if (m == MODE_START) begin
				center_col = cx;
				center_row = cy;
				step_x = REG_BITS'(r);
				step_y = '0;
				decision_error = 1 - int'(r);
				pen_color = col;
				circle_active = 1;
				emit_step();
			end else if (circle_active) begin
				emit_step();
			end
		endfunction

		function void check_result(point_rec_t got);
			point_rec_t want;
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected point x=%0d y=%0d addr=%h color=%h off=%b last=%b",
						got.px, got.py, got.addr, got.color, got.off, got.last);
				end
				return;
			end
			want = expected_points.pop_front();
			if (got.px !== want.px || got.py !== want.py || got.addr !== want.addr ||
					got.color !== want.color || got.off !== want.off ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("point mismatch: exp x=%0d y=%0d addr=%h color=%h off=%b last=%b",
						want.px, want.py, want.addr, want.color, want.off, want.last);
					$display("                got x=%0d y=%0d addr=%h color=%h off=%b last=%b",
						got.px, got.py, got.addr, got.color, got.off, got.last);
				end
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         mode = 1'b0;
	logic [COORD_BITS-1:0]        origin_x = '0;
	logic [COORD_BITS-1:0]        origin_y = '0;
	logic [RADIUS_BITS-1:0]       radius = '0;
	logic [COLOR_BITS-1:0]        color = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [POINT_BITS-1:0] point_x;
	logic signed [POINT_BITS-1:0] point_y;
	logic [ADDR_BITS-1:0]         byte_address;
	logic [COLOR_BITS-1:0]        pixel_color;
	logic                         off_screen;
	logic                         last_point;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic                         cfg_index = 1'b0;
	logic [REG_BITS-1:0]          cfg_data = '0;

	circle_scoreboard sb;
	int burst_left = 4;
	// Transactions that produce points; ignored continues are not counted.
	int drawing_items = 0;

	midpoint_circle_pixel_addresser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.radius(radius),
		.color(color),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_x(point_x),
		.point_y(point_y),
		.byte_address(byte_address),
		.pixel_color(pixel_color),
		.off_screen(off_screen),
		.last_point(last_point),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A hung block never drains its queue; this stops the run long after any correct
	// run would have finished.
	initial begin
		#8_000_000;
		$display("midpoint_circle_pixel_addresser regression: fail");
		$finish;
	end

	// Every point the sink takes is checked at the edge where it is accepted. Values are
	// read at the edge before any nonblocking update lands, so they are the ones the
	// block saw during the cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result('{point_x, point_y, byte_address, pixel_color, off_screen,
				last_point});
		end
	end

	// The sink stalls in styles that change at random: never, rarely, half the time, or in
	// long runs.
	initial begin
		int stall_style;
		int style_left;
		int run_left;
		bit run_stall;
		stall_style = 0;
		style_left = 0;
		run_left = 0;
		run_stall = 0;
		forever begin
			@(posedge clk);
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left = $urandom_range(20, 200);
			end
			style_left--;
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 7) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: begin
					if (run_left == 0) begin
						run_stall = !run_stall;
						run_left = run_stall ? $urandom_range(1, 12) : $urandom_range(1, 6);
					end
					run_left--;
					out_stall <= run_stall;
				end
			endcase
		end
	end

	// Offers one transaction and holds it until the block takes it. The source runs in
	// bursts; when a burst is used up it drops valid for a random gap. Within a burst valid
	// stays high and the next call just replaces the payload.
	task automatic send_item(mode_t m, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
			logic [RADIUS_BITS-1:0] r, logic [COLOR_BITS-1:0] col);
		in_valid <= 1'b1;
		mode <= m;
		origin_x <= cx;
		origin_y <= cy;
		radius <= r;
		color <= col;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (m == MODE_START || sb.active()) drawing_items++;
		sb.note_input(m, cx, cy, r, col);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
	endtask

	// A continue ignores every field but the mode, so its payload is random.
	task automatic send_continue();
		send_item(MODE_CONTINUE, COORD_BITS'($urandom), COORD_BITS'($urandom),
			RADIUS_BITS'($urandom), $urandom);
	endtask

	// Steps the circle in progress until it ends or the step budget runs out.
	task automatic finish_circle(int max_steps);
		int n;
		n = 0;
		while (sb.active() && n < max_steps) begin
			send_continue();
			n++;
		end
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [REG_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
	endtask

	// Waits for every predicted point, then keeps waiting so that a step still in flight
	// after an ignored continue cannot overlap a register write.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Screen geometries: the reset one, zero width, the largest legal one, a single
	// pixel, a stride large enough to wrap the address, and a random one.
	task automatic apply_screen(int choice);
		logic [REG_BITS-1:0] lw;
		logic [REG_BITS-1:0] rows;
		case (choice)
			0: begin
				lw = LINE_WIDTH_RESET;
				rows = SCREEN_HEIGHT_RESET;
			end
			1: begin
				lw = '0;
				rows = REG_BITS'($urandom_range(1, 4096));
			end
			2: begin
				lw = REG_BITS'(4096);
				rows = REG_BITS'(4096);
			end
			3: begin
				lw = REG_BITS'(1);
				rows = REG_BITS'(1);
			end
			4: begin
				lw = '1;
				rows = '1;
			end
			default: begin
				lw = REG_BITS'($urandom_range(1, 4096));
				rows = REG_BITS'($urandom_range(1, 4096));
			end
		endcase
		cfg_write(CFG_LINE_WIDTH, lw);
		cfg_write(CFG_SCREEN_HEIGHT, rows);
		cfg_valid <= 1'b0;
	endtask

	// One random drawing sequence: a start, then mostly a full circle, sometimes an early
	// abort (the next start drops it), with stray continues and random-mode noise mixed in.
	task automatic random_sequence();
		int pick;
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [RADIUS_BITS-1:0] r;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			cx = COORD_BITS'($urandom_range(0, 700));
			cy = COORD_BITS'($urandom_range(0, 500));
		end else if (pick < 8) begin
			cx = COORD_BITS'($urandom);
			cy = COORD_BITS'($urandom);
		end else begin
			cx = $urandom_range(0, 1) ? '1 : '0;
			cy = $urandom_range(0, 1) ? '1 : '0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			r = RADIUS_BITS'($urandom_range(0, 12));
		end else if (pick < 95) begin
			r = RADIUS_BITS'($urandom_range(13, 80));
		end else begin
			r = RADIUS_BITS'($urandom);
		end
		send_item(MODE_START, cx, cy, r, $urandom);
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			finish_circle(60);
		end else if (pick < 9) begin
			finish_circle($urandom_range(0, 4));
		end else begin
			repeat ($urandom_range(1, 3)) begin
				send_item(mode_t'(1'($urandom)), COORD_BITS'($urandom), COORD_BITS'($urandom),
					RADIUS_BITS'($urandom_range(0, 15)), $urandom);
			end
		end
		if ($urandom_range(0, 9) < 3) begin
			send_continue();
		end
	endtask

	initial begin
		int phase;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the reset geometry of 640 by 480.
		// A continue straight after reset has no circle to step and must vanish.
		send_continue();
		// Zero radius: one step, all eight points on the center, the eighth marked last.
		send_item(MODE_START, COORD_BITS'(320), COORD_BITS'(240), '0, '0);
		// The circle is over, so this continue is ignored as well.
		send_continue();
		// Radius one at the origin: the mirrored points fall off the top and left edges.
		send_item(MODE_START, '0, '0, RADIUS_BITS'(1), '1);
		send_item(MODE_START, COORD_BITS'(100), COORD_BITS'(100), RADIUS_BITS'(5),
			32'hA5A5_5A5A);
		finish_circle(10);
		// Largest center and radius; the points run far past the screen. A new start then
		// drops this circle partway through.
		send_item(MODE_START, '1, '1, '1, $urandom);
		finish_circle(3);
		// Center on the last visible pixel, so the points straddle the right and bottom edges.
		send_item(MODE_START, COORD_BITS'(639), COORD_BITS'(479), RADIUS_BITS'(3),
			32'h0000_FFFF);
		finish_circle(10);
		send_item(MODE_START, '1, '0, '0, 32'hFFFF_0000);
		send_continue();
		send_item(MODE_START, '0, '1, '1, 32'h1234_5678);
		finish_circle(2);

		// Random part. Each phase runs on a new geometry, written only once the block has
		// drained; the first phases walk through the extremes, later ones pick at random.
		phase = 0;
		drawing_items = 0;
		while (drawing_items < 150) begin
			if (drawing_items >= phase * 25) begin
				wait_idle();
				apply_screen(phase < 5 ? phase + 1 : $urandom_range(0, 5));
				phase++;
			end
			random_sequence();
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("midpoint_circle_pixel_addresser regression: pass");
		end else begin
			$display("midpoint_circle_pixel_addresser regression: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/mcpa_pkg.sv
sv/mcpa_front.sv
sv/mcpa_queue.sv
sv/mcpa_back.sv
sv/midpoint_circle_pixel_addresser.sv
test/midpoint_circle_pixel_addresser_tb.sv
